### rtl/task_timing_stats_table_unit_defines.svh
// Assertion macros for the back end of the task timing stats table RTL.
`ifndef TASK_TIMING_STATS_TABLE_UNIT_DEFINES_SVH
`define TASK_TIMING_STATS_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTST_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ttst_pkg.sv
// Types and fixed constants of the task timing stats table.
package ttst_pkg;

    // Fixed field widths of the item and result ports
    localparam int TIME_W   = 64;
    localparam int TAG_W    = 16;
    localparam int MEAS_W   = 32;
    localparam int CPU_W    = 2;
    localparam int TASK_W   = 3;
    localparam int HSLOT_W  = 4;
    localparam int CCOUNT_W = 4;
    localparam int TCOUNT_W = 6;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MEAS_W-1:0] MEAS_MAX = '1;

    typedef enum logic [1:0] {
        KIND_REGISTER = 2'd0,
        KIND_DELETE   = 2'd1,
        KIND_JITTER   = 2'd2,
        KIND_RUNTIME  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK              = 2'd0,
        STATUS_PERIOD_CONFLICT = 2'd1,
        STATUS_SLOT_OCCUPIED   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_back_state;

    // Classified event as it travels through the queue
    typedef struct packed {
        t_kind              kind;
        logic [CPU_W-1:0]   cpu;
        logic [TASK_W-1:0]  task_req;
        logic               in_range;
        logic [TIME_W-1:0]  period;
        logic [TAG_W-1:0]   name_tag;
        logic [TIME_W-1:0]  diff;
    } t_job;

    // Back-end status seen by the front end
    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

### rtl/ttst_front.sv
// Front end: accepts events, checks the index range and forms the time difference.
module ttst_front import ttst_pkg::*; #(
    parameter int CPU_COUNT     = 4,
    parameter int TASKS_PER_CPU = 8
) (
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_kind,
    input  logic [CPU_W-1:0]    i_cpu,
    input  logic [TASK_W-1:0]   i_task_req,
    input  logic [TIME_W-1:0]   i_period,
    input  logic [TAG_W-1:0]    i_name_tag,
    input  logic [TIME_W-1:0]   i_time_first,
    input  logic [TIME_W-1:0]   i_time_second,
    input  logic                i_q_full,
    input  t_back_status        i_back,
    output logic                o_q_push,
    output t_job                o_job
);

    logic [TIME_W-1:0] gap;

    // Hold off input while the queue is full or the slot memory is being cleared
    assign full     = i_q_full | i_back.clearing;
    assign o_q_push = push & ~full;

    // Classify and precompute the difference used by the back end
    always_comb begin
        gap            = i_time_second - i_time_first;
        o_job.kind     = t_kind'(i_kind);
        o_job.cpu      = i_cpu;
        o_job.task_req = i_task_req;
        o_job.in_range = (int'(i_cpu) < CPU_COUNT) && (int'(i_task_req) < TASKS_PER_CPU);
        o_job.period   = i_period;
        o_job.name_tag = i_name_tag;
        if (t_kind'(i_kind) == KIND_JITTER) begin
            o_job.diff = gap - i_period;
        end else begin
            o_job.diff = gap;
        end
    end

endmodule

### rtl/ttst_queue.sv
// Short job queue that decouples the front end from the back end.
module ttst_queue import ttst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (int'(r_cnt) == QUEUE_DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_slots[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (int'(r_wp) == QUEUE_DEPTH - 1) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (int'(r_rp) == QUEUE_DEPTH - 1) ? '0 : r_rp + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wp] <= i_job;
        end
    end

endmodule

### rtl/ttst_back.sv
// Back end: slot memory, per-CPU state, history rings and the result register.
`include "task_timing_stats_table_unit_defines.svh"
module ttst_back import ttst_pkg::*; #(
    parameter int CPU_COUNT     = 4,
    parameter int TASKS_PER_CPU = 8,
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  t_job                  i_q_job,
    output logic                  o_q_pop,
    output t_back_status          o_back,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_status,
    output logic [MEAS_W-1:0]     o_measured,
    output logic [HSLOT_W-1:0]    o_history_slot,
    output logic [CCOUNT_W-1:0]   o_cpu_task_count,
    output logic [TCOUNT_W-1:0]   o_total_task_count
);

    localparam int SLOT_TOTAL = CPU_COUNT * TASKS_PER_CPU;
    localparam int SIW        = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
    localparam int CIW        = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int PW         = $clog2(HISTORY_DEPTH);
    localparam int HIST_TOTAL = SLOT_TOTAL * HISTORY_DEPTH;
    localparam int HAW        = $clog2(HIST_TOTAL);
    localparam int CCW        = $clog2(TASKS_PER_CPU + 1);
    localparam int TCW        = $clog2(SLOT_TOTAL + 1);

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [PW-1:0]    jpos;
        logic [PW-1:0]    rpos;
    } t_slot_word;

    // Control state
    t_back_state       r_state;
    t_back_state       n_state;
    logic [SIW-1:0]    r_clr_addr;

    // Job being executed and its slot word
    t_job              r_job;
    logic [SIW-1:0]    r_slot;
    t_slot_word        r_rd_word;

    // Per-CPU and global state
    logic [TIME_W-1:0] r_cpu_period [CPU_COUNT];
    logic [CCW-1:0]    r_cpu_count  [CPU_COUNT];
    logic [TCW-1:0]    r_total;

    // Memories
    t_slot_word        r_slot_mem [SLOT_TOTAL];
    logic [MEAS_W-1:0] r_jit_mem  [HIST_TOTAL];
    logic [MEAS_W-1:0] r_run_mem  [HIST_TOTAL];

    // Result register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [MEAS_W-1:0]   r_out_measured;
    logic [HSLOT_W-1:0]  r_out_hslot;
    logic [CCOUNT_W-1:0] r_out_ccount;
    logic [TCOUNT_W-1:0] r_out_total;

    // Sequencer decode
    logic clear_we;
    logic issue;
    logic commit;
    logic out_free;

    // Execution datapath
    logic [SIW-1:0]    q_slot;
    logic [CIW-1:0]    cidx;
    logic [TIME_W-1:0] period_cur;
    logic [CCW-1:0]    cnt_cur;
    logic [TIME_W-1:0] mag;
    logic [MEAS_W-1:0] sat_mag;
    logic [MEAS_W-1:0] sat_diff;
    logic [PW-1:0]     pos;
    t_status           n_status;
    logic [MEAS_W-1:0] n_measured;
    logic [PW-1:0]     n_hpos;
    logic [CCW-1:0]    n_cnt;
    logic [TCW-1:0]    n_total;
    logic [TIME_W-1:0] n_period;
    t_slot_word        n_word;
    logic              slot_we;
    logic              jit_we;
    logic              run_we;
    logic [HAW-1:0]    hist_addr;

    assign out_free = ~r_out_valid | pop;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == SIW'(SLOT_TOTAL - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        clear_we = 1'b0;
        issue    = 1'b0;
        commit   = 1'b0;
        unique case (r_state)
            ST_CLEAR: clear_we = 1'b1;
            ST_IDLE:  issue    = ~i_q_empty;
            ST_EXEC:  commit   = out_free;
            default: begin
                clear_we = 1'b0;
            end
        endcase
    end

    assign o_q_pop         = issue;
    assign o_back.clearing = (r_state == ST_CLEAR);

    // Slot address of the job at the queue head
    assign q_slot = i_q_job.in_range
        ? SIW'(int'(i_q_job.cpu) * TASKS_PER_CPU + int'(i_q_job.task_req)) : '0;

    // Update of the addressed slot and CPU
    always_comb begin
        cidx       = CIW'(r_job.cpu);
        period_cur = r_cpu_period[cidx];
        cnt_cur    = r_cpu_count[cidx];
        mag        = r_job.diff[TIME_W-1] ? (~r_job.diff + TIME_W'(1)) : r_job.diff;
        sat_mag    = (|mag[TIME_W-1:MEAS_W]) ? MEAS_MAX : mag[MEAS_W-1:0];
        sat_diff   = (|r_job.diff[TIME_W-1:MEAS_W]) ? MEAS_MAX : r_job.diff[MEAS_W-1:0];
        pos        = '0;
        n_status   = STATUS_OK;
        n_measured = '0;
        n_hpos     = '0;
        n_cnt      = cnt_cur;
        n_total    = r_total;
        n_period   = period_cur;
        n_word     = r_rd_word;
        slot_we    = 1'b0;
        jit_we     = 1'b0;
        run_we     = 1'b0;
        if (r_job.in_range) begin
            unique case (r_job.kind)
                KIND_REGISTER: begin
                    if (period_cur != '0 && period_cur != r_job.period) begin
                        n_status = STATUS_PERIOD_CONFLICT;
                    end else if (r_rd_word.tag != '0) begin
                        n_status = STATUS_SLOT_OCCUPIED;
                    end else begin
                        n_period   = r_job.period;
                        n_word.tag = r_job.name_tag;
                        slot_we    = 1'b1;
                        if (int'(r_total) < SLOT_TOTAL) begin
                            n_total = r_total + TCW'(1);
                        end
                        if (int'(cnt_cur) < TASKS_PER_CPU) begin
                            n_cnt = cnt_cur + CCW'(1);
                        end
                    end
                end
                KIND_DELETE: begin
                    if (r_total != '0) begin
                        n_total = r_total - TCW'(1);
                    end
                    if (cnt_cur != '0) begin
                        n_cnt = cnt_cur - CCW'(1);
                    end
                    if (n_cnt == '0) begin
                        n_period = '0;
                    end
                    n_word.tag = '0;
                    slot_we    = 1'b1;
                end
                KIND_JITTER: begin
                    pos         = (int'(r_rd_word.jpos) >= HISTORY_DEPTH) ? '0 : r_rd_word.jpos;
                    n_word.jpos = (int'(pos) + 1 >= HISTORY_DEPTH) ? '0 : pos + PW'(1);
                    n_measured  = sat_mag;
                    n_hpos      = pos;
                    slot_we     = 1'b1;
                    jit_we      = 1'b1;
                end
                KIND_RUNTIME: begin
                    pos         = (int'(r_rd_word.rpos) >= HISTORY_DEPTH) ? '0 : r_rd_word.rpos;
                    n_word.rpos = (int'(pos) + 1 >= HISTORY_DEPTH) ? '0 : pos + PW'(1);
                    n_measured  = sat_diff;
                    n_hpos      = pos;
                    slot_we     = 1'b1;
                    run_we      = 1'b1;
                end
                default: begin
                    slot_we = 1'b0;
                end
            endcase
        end
        hist_addr = HAW'(int'(r_slot) * HISTORY_DEPTH + int'(pos));
    end

    // Control registers, per-CPU state and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CPU_COUNT; i++) begin
                r_cpu_period[i] <= '0;
                r_cpu_count[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (clear_we) begin
                r_clr_addr <= r_clr_addr + SIW'(1);
            end
            if (commit && r_job.in_range) begin
                r_total            <= n_total;
                r_cpu_count[cidx]  <= n_cnt;
                r_cpu_period[cidx] <= n_period;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job capture and result payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_job  <= i_q_job;
            r_slot <= q_slot;
        end
        if (commit) begin
            r_out_status   <= n_status;
            r_out_measured <= n_measured;
            r_out_hslot    <= HSLOT_W'(n_hpos);
            r_out_ccount   <= r_job.in_range ? CCOUNT_W'(n_cnt) : '0;
            r_out_total    <= TCOUNT_W'(n_total);
        end
    end

    // Slot memory: clearing pass, read on issue, write on commit
    always_ff @(posedge i_clk) begin
        if (clear_we) begin
            r_slot_mem[r_clr_addr] <= '0;
        end else if (commit && slot_we) begin
            r_slot_mem[r_slot] <= n_word;
        end
        if (issue) begin
            r_rd_word <= r_slot_mem[q_slot];
        end
    end

    // History rings
    always_ff @(posedge i_clk) begin
        if (commit && jit_we) begin
            r_jit_mem[hist_addr] <= n_measured;
        end
        if (commit && run_we) begin
            r_run_mem[hist_addr] <= n_measured;
        end
    end

    assign empty              = ~r_out_valid;
    assign o_status           = r_out_status;
    assign o_measured         = r_out_measured;
    assign o_history_slot     = r_out_hslot;
    assign o_cpu_task_count   = r_out_ccount;
    assign o_total_task_count = r_out_total;

    // Checks
    `TTST_ASSERT_IMPL(a_commit_room, i_clk, i_rst_n, commit, !r_out_valid || pop, "result overwritten before transfer")
    `TTST_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, commit, r_out_valid, "committed result not presented")
    `TTST_ASSERT_IMPL(a_clear_quiet, i_clk, i_rst_n, r_state == ST_CLEAR, !o_q_pop && !r_out_valid, "job activity during clearing pass")
    `TTST_ASSERT_IMPL(a_total_bound, i_clk, i_rst_n, 1'b1, int'(r_total) <= SLOT_TOTAL, "total task count above slot total")

endmodule

### rtl/task_timing_stats_table_unit.sv
// Top level of the task timing stats table unit.
// Events (register, delete, jitter record, run time record) enter through a
// queue-style input and yield one result each, in order, through a queue-style
// output. The front end checks the index range and forms the time difference;
// a two-entry job queue feeds the back end, which handles each event in an idle
// state that reads the slot word from the slot memory and then an execute state
// that updates the slot, the per-CPU period and counts, and the history ring,
// and loads the result register. This slot memory read-modify-write limits the
// sustained rate: the back end takes no new event from the queue until the
// previous one has loaded the result register, and the execute state waits
// while the result register still holds an untaken result. After reset a
// clearing pass over all CPU_COUNT*TASKS_PER_CPU slot words empties the slot
// memory, with full held high throughout.
module task_timing_stats_table_unit import ttst_pkg::*; #(
    parameter int CPU_COUNT     = 4,
    parameter int TASKS_PER_CPU = 8,
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_kind,
    input  logic [CPU_W-1:0]    i_cpu,
    input  logic [TASK_W-1:0]   i_task_req,
    input  logic [TIME_W-1:0]   i_period,
    input  logic [TAG_W-1:0]    i_name_tag,
    input  logic [TIME_W-1:0]   i_time_first,
    input  logic [TIME_W-1:0]   i_time_second,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          o_status,
    output logic [MEAS_W-1:0]   o_measured,
    output logic [HSLOT_W-1:0]  o_history_slot,
    output logic [CCOUNT_W-1:0] o_cpu_task_count,
    output logic [TCOUNT_W-1:0] o_total_task_count
);

    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_empty;
    t_job         front_job;
    t_job         head_job;
    t_back_status back_status;

    // Front end
    ttst_front #(
        .CPU_COUNT     (CPU_COUNT),
        .TASKS_PER_CPU (TASKS_PER_CPU)
    ) u_front (
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_cpu         (i_cpu),
        .i_task_req    (i_task_req),
        .i_period      (i_period),
        .i_name_tag    (i_name_tag),
        .i_time_first  (i_time_first),
        .i_time_second (i_time_second),
        .i_q_full      (q_full),
        .i_back        (back_status),
        .o_q_push      (q_push),
        .o_job         (front_job)
    );

    // Job queue
    ttst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    // Back end
    ttst_back #(
        .CPU_COUNT     (CPU_COUNT),
        .TASKS_PER_CPU (TASKS_PER_CPU),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (q_empty),
        .i_q_job            (head_job),
        .o_q_pop            (q_pop),
        .o_back             (back_status),
        .empty              (empty),
        .pop                (pop),
        .o_status           (o_status),
        .o_measured         (o_measured),
        .o_history_slot     (o_history_slot),
        .o_cpu_task_count   (o_cpu_task_count),
        .o_total_task_count (o_total_task_count)
    );

endmodule

### sim/task_timing_stats_table_unit_test.sv
// Self-checking testbench for the task timing stats table unit: directed and random event traffic.
`timescale 1ns / 1ps

module task_timing_stats_table_unit_test;
    import ttst_pkg::*;

    localparam int CPUS          = 4;
    localparam int SLOTS_PER_CPU = 8;
    localparam int RING_DEPTH    = 16;
    localparam int SLOTS         = CPUS * SLOTS_PER_CPU;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PHASE_EVENTS  = 160;

    typedef struct packed {
        t_kind              kind;
        logic [CPU_W-1:0]   cpu;
        logic [TASK_W-1:0]  task_req;
        logic [TIME_W-1:0]  period;
        logic [TAG_W-1:0]   name_tag;
        logic [TIME_W-1:0]  time_first;
        logic [TIME_W-1:0]  time_second;
    } table_event_t;

    typedef struct packed {
        t_status              status;
        logic [MEAS_W-1:0]    measured;
        logic [HSLOT_W-1:0]   history_slot;
        logic [CCOUNT_W-1:0]  cpu_tasks;
        logic [TCOUNT_W-1:0]  all_tasks;
    } table_result_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    logic [1:0]          i_kind;
    logic [CPU_W-1:0]    i_cpu;
    logic [TASK_W-1:0]   i_task_req;
    logic [TIME_W-1:0]   i_period;
    logic [TAG_W-1:0]    i_name_tag;
    logic [TIME_W-1:0]   i_time_first;
    logic [TIME_W-1:0]   i_time_second;
    logic                empty;
    logic                pop;
    logic [1:0]          o_status;
    logic [MEAS_W-1:0]   o_measured;
    logic [HSLOT_W-1:0]  o_history_slot;
    logic [CCOUNT_W-1:0] o_cpu_task_count;
    logic [TCOUNT_W-1:0] o_total_task_count;

    // Shadow copy of the table state
    logic [TIME_W-1:0]   cpu_period_q  [CPUS];
    logic [CCOUNT_W-1:0] cpu_tasks_q   [CPUS];
    logic [TCOUNT_W-1:0] all_tasks_q;
    logic [TAG_W-1:0]    slot_tag_q    [SLOTS];
    logic [HSLOT_W-1:0]  jitter_pos_q  [SLOTS];
    logic [HSLOT_W-1:0]  runtime_pos_q [SLOTS];

    table_result_t pending_results[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_asked;
    int hold_served;
    int hold_left;
    int quiet_cycles;
    int mismatch_count;
    int results_checked;
    int kind_tally[4];
    int saturated_samples;
    int refused_registers;

    task_timing_stats_table_unit #(
        .CPU_COUNT     (CPUS),
        .TASKS_PER_CPU (SLOTS_PER_CPU),
        .HISTORY_DEPTH (RING_DEPTH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_kind             (i_kind),
        .i_cpu              (i_cpu),
        .i_task_req         (i_task_req),
        .i_period           (i_period),
        .i_name_tag         (i_name_tag),
        .i_time_first       (i_time_first),
        .i_time_second      (i_time_second),
        .empty              (empty),
        .pop                (pop),
        .o_status           (o_status),
        .o_measured         (o_measured),
        .o_history_slot     (o_history_slot),
        .o_cpu_task_count   (o_cpu_task_count),
        .o_total_task_count (o_total_task_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Saturate a 64-bit sample to the 32-bit history word
    function automatic logic [MEAS_W-1:0] clamp_sample(input logic [TIME_W-1:0] v);
        return (v > {32'd0, MEAS_MAX}) ? MEAS_MAX : v[MEAS_W-1:0];
    endfunction

    // Apply one event to the shadow table and return the result it yields
    function automatic table_result_t predict_event(input table_event_t ev);
        table_result_t     res;
        int unsigned       s;
        logic [TIME_W-1:0] gap;
        res.status       = STATUS_OK;
        res.measured     = '0;
        res.history_slot = '0;
        s = ev.cpu * SLOTS_PER_CPU + ev.task_req;
        case (ev.kind)
            KIND_REGISTER: begin
                // period check wins over the occupancy check
                if (cpu_period_q[ev.cpu] != 0 && cpu_period_q[ev.cpu] != ev.period) begin
                    res.status = STATUS_PERIOD_CONFLICT;
                end else if (slot_tag_q[s] != 0) begin
                    res.status = STATUS_SLOT_OCCUPIED;
                end else begin
                    cpu_period_q[ev.cpu] = ev.period;
                    if (all_tasks_q < SLOTS) all_tasks_q++;
                    if (cpu_tasks_q[ev.cpu] < SLOTS_PER_CPU) cpu_tasks_q[ev.cpu]++;
                    slot_tag_q[s] = ev.name_tag;
                end
                if (res.status != STATUS_OK) refused_registers++;
            end
            KIND_DELETE: begin
                if (all_tasks_q > 0) all_tasks_q--;
                if (cpu_tasks_q[ev.cpu] > 0) cpu_tasks_q[ev.cpu]--;
                if (cpu_tasks_q[ev.cpu] == 0) cpu_period_q[ev.cpu] = '0;
                slot_tag_q[s] = '0;
            end
            KIND_JITTER: begin
                gap = ev.time_second - ev.time_first - ev.period;
                if (gap[TIME_W-1]) gap = -gap;
                res.measured     = clamp_sample(gap);
                res.history_slot = jitter_pos_q[s];
                jitter_pos_q[s]  = (jitter_pos_q[s] + 1 >= RING_DEPTH) ? '0 : jitter_pos_q[s] + 1'b1;
                if (gap > {32'd0, MEAS_MAX}) saturated_samples++;
            end
            default: begin
                gap = ev.time_second - ev.time_first;
                res.measured     = clamp_sample(gap);
                res.history_slot = runtime_pos_q[s];
                runtime_pos_q[s] = (runtime_pos_q[s] + 1 >= RING_DEPTH) ? '0 : runtime_pos_q[s] + 1'b1;
                if (gap > {32'd0, MEAS_MAX}) saturated_samples++;
            end
        endcase
        res.cpu_tasks = cpu_tasks_q[ev.cpu];
        res.all_tasks = all_tasks_q;
        return res;
    endfunction

    function automatic table_event_t ev_of(input t_kind k, input int c, input int t,
                                           input logic [TIME_W-1:0] per,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [TIME_W-1:0] t1,
                                           input logic [TIME_W-1:0] t2);
        table_event_t ev;
        ev.kind        = k;
        ev.cpu         = c[CPU_W-1:0];
        ev.task_req    = t[TASK_W-1:0];
        ev.period      = per;
        ev.name_tag    = tag;
        ev.time_first  = t1;
        ev.time_second = t2;
        return ev;
    endfunction

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly the CPU's current period, so registrations and jitter stay sensible
    function automatic logic [TIME_W-1:0] pick_period(input int c);
        int r;
        r = $urandom_range(99);
        if (cpu_period_q[c] != 0 && r < 75) return cpu_period_q[c];
        if (r >= 90) return rand64();
        case ($urandom_range(3))
            0:       return 64'd1000;
            1:       return 64'd250000;
            2:       return 64'hFFFF_FFFF;
            default: return 64'd0;
        endcase
    endfunction

    // Random event; a share of the traffic lands on two slots of CPU 0 so rings wrap
    function automatic table_event_t random_event(input int reg_pct, input int del_pct);
        table_event_t      ev;
        int                r;
        logic [TIME_W-1:0] delta;
        if ($urandom_range(99) < 30) begin
            ev.cpu      = '0;
            ev.task_req = TASK_W'($urandom_range(1));
        end else begin
            ev.cpu      = CPU_W'($urandom_range(CPUS - 1));
            ev.task_req = TASK_W'($urandom_range(SLOTS_PER_CPU - 1));
        end
        ev.period      = rand64();
        ev.name_tag    = TAG_W'($urandom_range(65535));
        ev.time_first  = rand64();
        ev.time_second = rand64();
        r = $urandom_range(99);
        if (r < reg_pct) begin
            ev.kind   = KIND_REGISTER;
            ev.period = pick_period(ev.cpu);
            if ($urandom_range(99) < 30) ev.name_tag = '0;
        end else if (r < reg_pct + del_pct) begin
            ev.kind = KIND_DELETE;
        end else if ($urandom_range(1)) begin
            ev.kind   = KIND_JITTER;
            ev.period = pick_period(ev.cpu);
            r = $urandom_range(9);
            if (r == 0) begin
                ev.time_second = rand64();
            end else if (r == 1) begin
                delta = {32'd0, $urandom} << $urandom_range(32);
                ev.time_second = ev.time_first + ev.period + delta;
            end else begin
                delta = $urandom_range(4000);
                ev.time_second = ev.time_first + ev.period + delta - 64'd2000;
            end
        end else begin
            ev.kind = KIND_RUNTIME;
            r = $urandom_range(19);
            if (r == 0) begin
                ev.time_second = ev.time_first - $urandom_range(1000);
            end else if (r > 2) begin
                ev.time_second = ev.time_first + $urandom_range(200000);
            end
        end
        return ev;
    endfunction

    // Offer one event; entered and left at a falling edge
    task automatic send_event(input table_event_t ev);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_kind        <= ev.kind;
        i_cpu         <= ev.cpu;
        i_task_req    <= ev.task_req;
        i_period      <= ev.period;
        i_name_tag    <= ev.name_tag;
        i_time_first  <= ev.time_first;
        i_time_second <= ev.time_second;
        do @(posedge i_clk); while (full);
        pending_results.push_back(predict_event(ev));
        kind_tally[ev.kind]++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Receiver: random stalls plus long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // Compare each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        table_result_t want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'd0, {62'd0, o_status});
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_status !== want.status)
                    report_mismatch("status", want.status, o_status);
                if (o_measured !== want.measured)
                    report_mismatch("measured", want.measured, o_measured);
                if (o_history_slot !== want.history_slot)
                    report_mismatch("history_slot", want.history_slot, o_history_slot);
                if (o_cpu_task_count !== want.cpu_tasks)
                    report_mismatch("cpu_task_count", want.cpu_tasks, o_cpu_task_count);
                if (o_total_task_count !== want.all_tasks)
                    report_mismatch("total_task_count", want.all_tasks, o_total_task_count);
            end
        end
    end

    // Watchdog on stretches with no transfer on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("task_timing_stats_table_unit verification failed");
            $finish;
        end
    end

    // Period check, occupancy, zero tag and per-CPU period ownership
    task automatic test_register_rules();
        send_event(ev_of(KIND_REGISTER, 0, 0, 64'd100, 16'hA5A5, '0, '0));
        send_event(ev_of(KIND_REGISTER, 0, 1, 64'd200, 16'h0001, '0, '0));
        send_event(ev_of(KIND_REGISTER, 0, 0, 64'd100, 16'h0001, '0, '0));
        send_event(ev_of(KIND_REGISTER, 0, 2, 64'd100, 16'h0000, '0, '0));
        send_event(ev_of(KIND_REGISTER, 0, 2, 64'd100, 16'hFFFF, '0, '0));
        send_event(ev_of(KIND_REGISTER, 1, 7, '1, 16'hFFFF, '1, '1));
        send_event(ev_of(KIND_REGISTER, 3, 7, 64'd0, 16'h8000, '0, '0));
        send_event(ev_of(KIND_REGISTER, 3, 6, 64'd5, 16'h7FFF, '0, '0));
    endtask

    // Delete has no checks: empty CPU clamps at zero, last task clears the period
    task automatic test_delete_rules();
        send_event(ev_of(KIND_DELETE, 0, 0, '1, '1, '1, '1));
        send_event(ev_of(KIND_DELETE, 2, 3, '0, '0, '0, '0));
        send_event(ev_of(KIND_DELETE, 1, 7, '0, '0, '0, '0));
        send_event(ev_of(KIND_REGISTER, 1, 0, 64'd7, 16'h1234, '0, '0));
    endtask

    // Jitter sign handling, saturation and 64-bit wrap
    task automatic test_jitter_records();
        send_event(ev_of(KIND_JITTER, 2, 4, 64'd100, '0, 64'd1000, 64'd1100));
        send_event(ev_of(KIND_JITTER, 2, 4, 64'd100, '0, 64'd1000, 64'd1177));
        send_event(ev_of(KIND_JITTER, 2, 4, 64'd100, '0, 64'd1000, 64'd1095));
        send_event(ev_of(KIND_JITTER, 2, 4, 64'd100, '0, 64'd5000, 64'd5100 + (64'd1 << 40)));
        send_event(ev_of(KIND_JITTER, 2, 4, 64'd0, '0, 64'd0, 64'h8000_0000_0000_0000));
        send_event(ev_of(KIND_JITTER, 2, 4, 64'd0, '0, 64'h1_0000_0000, 64'd1));
        send_event(ev_of(KIND_JITTER, 2, 4, 64'd0, '0, '1, 64'd0));
        send_event(ev_of(KIND_JITTER, 2, 4, '1, '0, 64'd0, 64'd0));
    endtask

    // Run time: zero, exact 32-bit maximum, saturation, end before start
    task automatic test_runtime_records();
        send_event(ev_of(KIND_RUNTIME, 2, 4, '0, '0, 64'd123, 64'd123));
        send_event(ev_of(KIND_RUNTIME, 2, 4, '0, '0, 64'h10, 64'h10 + 64'hFFFF_FFFF));
        send_event(ev_of(KIND_RUNTIME, 2, 4, '0, '0, 64'd0, 64'h1_0000_0000));
        send_event(ev_of(KIND_RUNTIME, 2, 4, '0, '0, 64'd500, 64'd499));
        send_event(ev_of(KIND_RUNTIME, 2, 4, '0, '0, '1, 64'd5));
    endtask

    // Random traffic in idling phases with shifting event mixes
    task automatic test_random_traffic();
        int phase;
        int n;
        int reg_pct[4];
        int del_pct[4];
        int send_pct[4];
        int recv_pct[4];
        reg_pct  = '{30, 60, 20, 30};
        del_pct  = '{20, 10, 40, 20};
        send_pct = '{0, 64, 0, 11};
        recv_pct = '{0, 0, 64, 11};
        for (phase = 0; phase < 4; phase++) begin
            set_idling(send_pct[phase], recv_pct[phase]);
            for (n = 0; n < PHASE_EVENTS; n++)
                send_event(random_event(reg_pct[phase], del_pct[phase]));
            wait_drained();
        end
    endtask

    // Long receiver hold-off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        int n;
        set_idling(0, 0);
        hold_asked++;
        for (n = 0; n < 40; n++) send_event(random_event(30, 20));
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        i_kind         = KIND_REGISTER;
        i_cpu          = '0;
        i_task_req     = '0;
        i_period       = '0;
        i_name_tag     = '0;
        i_time_first   = '0;
        i_time_second  = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asked     = 0;
        hold_served    = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        mismatch_count = 0;
        results_checked   = 0;
        saturated_samples = 0;
        refused_registers = 0;
        kind_tally     = '{0, 0, 0, 0};
        all_tasks_q    = '0;
        for (int i = 0; i < CPUS; i++) begin
            cpu_period_q[i] = '0;
            cpu_tasks_q[i]  = '0;
        end
        for (int i = 0; i < SLOTS; i++) begin
            slot_tag_q[i]    = '0;
            jitter_pos_q[i]  = '0;
            runtime_pos_q[i] = '0;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_register_rules();
        test_delete_rules();
        test_jitter_records();
        test_runtime_records();
        test_random_traffic();
        test_backpressure();

        // Let any stray result surface before the final check
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d predicted results never arrived", pending_results.size());
            mismatch_count += pending_results.size();
        end

        $display("events: %0d register (%0d refused), %0d delete, %0d jitter, %0d run time",
                 kind_tally[KIND_REGISTER], refused_registers, kind_tally[KIND_DELETE],
                 kind_tally[KIND_JITTER], kind_tally[KIND_RUNTIME]);
        $display("results checked: %0d, saturated samples: %0d, mismatches: %0d",
                 results_checked, saturated_samples, mismatch_count);
        if (mismatch_count == 0) begin
            $display("task_timing_stats_table_unit verification clean");
        end else begin
            $display("task_timing_stats_table_unit verification failed");
        end
        $finish;
    end

endmodule
